// ===== hdl/rgbe_pkg.sv =====
// rgbe encoder package: payload structs, register indexes, constants and a bit-length helper
package rgbe_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgBlackThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgExponentBias   = 1'b1;

  localparam logic [30:0] BlackThresholdReset = 31'd172994847;
  localparam logic [7:0]  ExponentBiasReset   = 8'd128;

  typedef struct packed {
    logic [31:0] red_bits;
    logic [31:0] green_bits;
    logic [31:0] blue_bits;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_mantissa;
    logic [7:0] green_mantissa;
    logic [7:0] blue_mantissa;
    logic [7:0] shared_exponent;
    logic       overflow;
  } pixel_out_t;

  // bit length of a 24-bit significand, 0..24
  function automatic logic [4:0] bit_len24(input logic [23:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== hdl/rgbe_max_stage.sv =====
// stage 1: special detect, largest channel select and black test
module rgbe_max_stage import rgbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  pixel_in_t   pix_i,
  input  logic [30:0] black_threshold_i,
  output logic        valid_o,
  output pixel_in_t   pix_o,
  output logic [31:0] best_o,
  output logic        special_o,
  output logic        black_o
);

  logic        valid_q;
  pixel_in_t   pix_q;
  logic [31:0] best_q, best_d;
  logic        special_q, special_d, black_q, black_d;
  logic [31:0] key_r, key_g, key_b, key_rg;
  logic [31:0] best_rg;

  function automatic logic [31:0] order_key(input logic [31:0] v);
    return v[31] ? ~v : (v | 32'h8000_0000);
  endfunction

  always_comb begin
    special_d = (pix_i.red_bits[30:23] == 8'hFF) || (pix_i.green_bits[30:23] == 8'hFF) ||
                (pix_i.blue_bits[30:23] == 8'hFF);
    key_r = order_key(pix_i.red_bits);
    key_g = order_key(pix_i.green_bits);
    key_b = order_key(pix_i.blue_bits);
    best_rg = (key_g > key_r) ? pix_i.green_bits : pix_i.red_bits;
    key_rg  = (key_g > key_r) ? key_g : key_r;
    best_d  = (key_b > key_rg) ? pix_i.blue_bits : best_rg;
    black_d = best_d[31] || (best_d <= {1'b0, black_threshold_i}) || (best_d == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_i;
    best_q    <= best_d;
    special_q <= special_d;
    black_q   <= black_d;
  end

  assign valid_o   = valid_q;
  assign pix_o     = pix_q;
  assign best_o    = best_q;
  assign special_o = special_q;
  assign black_o   = black_q;

endmodule

// ===== hdl/rgbe_exp_stage.sv =====
// stage 2: shared exponent and biased exponent range checks
module rgbe_exp_stage import rgbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pixel_in_t          pix_i,
  input  logic [31:0]        best_i,
  input  logic               special_i,
  input  logic               black_i,
  input  logic [7:0]         exponent_bias_i,
  output logic               valid_o,
  output pixel_in_t          pix_o,
  output logic signed [9:0]  exp_o,
  output logic [7:0]         biased_o,
  output logic               sat_o,
  output logic               zero_o
);

  logic              valid_q;
  pixel_in_t         pix_q;
  logic signed [9:0] exp_q, exp_d;
  logic [7:0]        biased_q;
  logic              sat_q, sat_d, zero_q, zero_d;
  logic [23:0]       mant;
  logic signed [9:0] pw;
  logic signed [10:0] biased_d;

  always_comb begin
    if (best_i[30:23] != 8'd0) begin
      mant = {1'b1, best_i[22:0]};
      pw   = $signed({2'b00, best_i[30:23]}) - 10'sd150;
    end else begin
      mant = {1'b0, best_i[22:0]};
      pw   = -10'sd149;
    end
    exp_d    = $signed({5'd0, bit_len24(mant)}) + pw;
    biased_d = 11'(exp_d) + $signed({3'd0, exponent_bias_i});
    sat_d    = special_i || (!black_i && biased_d > 11'sd255);
    zero_d   = !special_i && (black_i || biased_d < 11'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_i;
    exp_q    <= exp_d;
    biased_q <= biased_d[7:0];
    sat_q    <= sat_d;
    zero_q   <= zero_d;
  end

  assign valid_o  = valid_q;
  assign pix_o    = pix_q;
  assign exp_o    = exp_q;
  assign biased_o = biased_q;
  assign sat_o    = sat_q;
  assign zero_o   = zero_q;

endmodule

// ===== hdl/rgbe_chan_scale.sv =====
// one channel scaled by the shared exponent, a barrel shift
module rgbe_chan_scale (
  input  logic [31:0]       v_i,
  input  logic signed [9:0] exp_i,
  output logic [7:0]        mant_o
);

  logic [23:0]        mant;
  logic signed [9:0]  pw;
  logic signed [10:0] s;
  logic [4:0]         rsh;

  always_comb begin
    if (v_i[30:23] != 8'd0) begin
      mant = {1'b1, v_i[22:0]};
      pw   = $signed({2'b00, v_i[30:23]}) - 10'sd150;
    end else begin
      mant = {1'b0, v_i[22:0]};
      pw   = -10'sd149;
    end
    s      = 11'(pw) + 11'sd8 - 11'(exp_i);
    rsh    = 5'(-s);
    mant_o = 8'd0;
    if (v_i[31] || v_i[30:0] == 31'd0) begin
      mant_o = 8'd0;
    end else if (s >= 11'sd8) begin
      mant_o = 8'hFF;
    end else if (s >= 11'sd0) begin
      mant_o = 8'(mant << s[2:0]);
    end else if (s > -11'sd32) begin
      mant_o = 8'(mant >> rsh);
    end
  end

endmodule

// ===== hdl/rgbe_shared_exponent_encoder.sv =====
// rgbe shared exponent encoder top level: config registers and output stage
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------
//  input   | start / busy            | pix_i (pixel_in_t)
//  result  | done_o strobe           | pix_o (pixel_out_t)
//  config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// three register stages: max select, exponent, channel shift
// one item per clock; a started item passes the max select, exponent and output registers in turn
// busy is always low; reset clears the valid bits and loads the config defaults
// results cannot be held off, so nothing in the pipe ever stalls
module rgbe_shared_exponent_encoder import rgbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pixel_in_t          pix_i,
  output logic               done_o,
  output pixel_out_t         pix_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [30:0] black_threshold_q;
  logic [7:0]  exponent_bias_q;

  logic        s1_valid, s1_special, s1_black;
  pixel_in_t   s1_pix;
  logic [31:0] s1_best;

  logic              s2_valid, s2_sat, s2_zero;
  pixel_in_t         s2_pix;
  logic signed [9:0] s2_exp;
  logic [7:0]        s2_biased;

  logic [7:0] r_m, g_m, b_m;
  logic       done_q;
  pixel_out_t out_q, out_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_threshold_q <= BlackThresholdReset;
      exponent_bias_q   <= ExponentBiasReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgBlackThreshold: black_threshold_q <= cfg_data_i[30:0];
        CfgExponentBias:   exponent_bias_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  rgbe_max_stage u_max (
    .clk_i, .rst_ni,
    .valid_i(start && !busy), .pix_i,
    .black_threshold_i(black_threshold_q),
    .valid_o(s1_valid), .pix_o(s1_pix), .best_o(s1_best),
    .special_o(s1_special), .black_o(s1_black)
  );

  rgbe_exp_stage u_exp (
    .clk_i, .rst_ni,
    .valid_i(s1_valid), .pix_i(s1_pix), .best_i(s1_best),
    .special_i(s1_special), .black_i(s1_black),
    .exponent_bias_i(exponent_bias_q),
    .valid_o(s2_valid), .pix_o(s2_pix), .exp_o(s2_exp),
    .biased_o(s2_biased), .sat_o(s2_sat), .zero_o(s2_zero)
  );

  rgbe_chan_scale u_r (.v_i(s2_pix.red_bits),   .exp_i(s2_exp), .mant_o(r_m));
  rgbe_chan_scale u_g (.v_i(s2_pix.green_bits), .exp_i(s2_exp), .mant_o(g_m));
  rgbe_chan_scale u_b (.v_i(s2_pix.blue_bits),  .exp_i(s2_exp), .mant_o(b_m));

  always_comb begin
    if (s2_sat) begin
      out_d = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
    end else if (s2_zero) begin
      out_d = '0;
    end else begin
      out_d = '{r_m, g_m, b_m, s2_biased, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign pix_o  = out_q;

  // an accepted item always comes out with a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done_o) else $error("result strobe missing");
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && pix_o.overflow |-> pix_o.shared_exponent == 8'hFF)
    else $error("overflow without saturation");
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && pix_o.shared_exponent == 8'd0 |-> !pix_o.overflow)
    else $error("zero exponent with overflow");

endmodule
